### rtl/source_code_tokenizer_defines.svh
// Assertion macros used by the tokenizer checker.
`ifndef SOURCE_CODE_TOKENIZER_DEFINES_SVH
`define SOURCE_CODE_TOKENIZER_DEFINES_SVH

// Check out of reset.
`define SCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define SCT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/sct_pkg.sv
// Types and constants of the source code tokenizer.
package sct_pkg;

  localparam int LINE_W = 20;
  localparam int COL_W  = 16;
  localparam int LEN_W  = 16;
  localparam int MAX_RES = 4;

  localparam logic [LINE_W-1:0] LINE_TOP = '1;
  localparam logic [COL_W-1:0]  COL_TOP  = '1;
  localparam logic [LEN_W-1:0]  LEN_TOP  = '1;

  typedef enum logic [2:0] {
    TK_INT    = 3'd0,
    TK_FLOAT  = 3'd1,
    TK_IDENT  = 3'd2,
    TK_STRING = 3'd3,
    TK_PUNCT  = 3'd4,
    TK_END    = 3'd5,
    TK_BADNUM = 3'd6,
    TK_UNTERM = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    PC_SINGLE = 4'd0,
    PC_EQ     = 4'd1,
    PC_NE     = 4'd2,
    PC_LE     = 4'd3,
    PC_GE     = 4'd4,
    PC_AND    = 4'd5,
    PC_OR     = 4'd6,
    PC_ARROW  = 4'd7,
    PC_FATARR = 4'd8,
    PC_ELLIP  = 4'd9,
    PC_RANGE  = 4'd10
  } pcode_t;

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_NUM   = 4'd1,
    M_IDENT = 4'd2,
    M_STR   = 4'd3,
    M_LCOM  = 4'd4,
    M_BCOM  = 4'd5,
    M_BSTAR = 4'd6,
    M_PEND  = 4'd7,
    M_HELD  = 4'd8
  } mode_t;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [2:0]        token_kind;
    logic [3:0]        punct_code;
    logic [7:0]        first_char;
    logic [LINE_W-1:0] start_line;
    logic [COL_W-1:0]  start_column;
    logic [LEN_W-1:0]  token_length;
    logic              space_before;
    logic              space_after;
    logic              last_result;
  } tok_t;

  // Results of one byte, handed from the scanner to the queue.
  typedef struct packed {
    logic [2:0]           cnt;
    tok_t [MAX_RES-1:0]   tok;
  } push_t;

endpackage

### rtl/sct_step.sv
// Scanner: input register, lexer state and per-byte result generation.
module sct_step (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  sct_pkg::in_t in_data,
  input  logic         go,
  output logic         busy,
  output sct_pkg::push_t push
);
  import sct_pkg::*;

  function automatic logic [LINE_W-1:0] inc_line(input logic [LINE_W-1:0] v);
    return (v == LINE_TOP) ? v : v + 1'b1;
  endfunction
  function automatic logic [COL_W-1:0] inc_col(input logic [COL_W-1:0] v);
    return (v == COL_TOP) ? v : v + 1'b1;
  endfunction
  function automatic logic [LEN_W-1:0] inc_len(input logic [LEN_W-1:0] v);
    return (v == LEN_TOP) ? v : v + 1'b1;
  endfunction
  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction
  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
  endfunction
  function automatic logic is_ws(input logic [7:0] b);
    return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
  endfunction
  function automatic logic starts_pend(input logic [7:0] b);
    return b == CH_SLASH || b == CH_EQ || b == CH_BANG || b == CH_LT || b == CH_GT ||
           b == CH_AMP || b == CH_BAR || b == CH_MINUS || b == CH_DOT;
  endfunction
  function automatic pcode_t pair_code(input logic [7:0] a, input logic [7:0] b);
    pcode_t c;
    c = PC_SINGLE;
    if (a == CH_EQ && b == CH_EQ) c = PC_EQ;
    else if (a == CH_BANG && b == CH_EQ) c = PC_NE;
    else if (a == CH_LT && b == CH_EQ) c = PC_LE;
    else if (a == CH_GT && b == CH_EQ) c = PC_GE;
    else if (a == CH_AMP && b == CH_AMP) c = PC_AND;
    else if (a == CH_BAR && b == CH_BAR) c = PC_OR;
    else if (a == CH_MINUS && b == CH_GT) c = PC_ARROW;
    else if (a == CH_EQ && b == CH_GT) c = PC_FATARR;
    return c;
  endfunction
  function automatic tok_t mk(input logic [2:0] k, input logic [3:0] c, input logic [7:0] f,
                              input logic [LINE_W-1:0] ln, input logic [COL_W-1:0] col,
                              input logic [LEN_W-1:0] len, input logic sb, input logic sa);
    tok_t t;
    t.token_kind   = k;
    t.punct_code   = c;
    t.first_char   = f;
    t.start_line   = ln;
    t.start_column = col;
    t.token_length = len;
    t.space_before = sb;
    t.space_after  = sa;
    t.last_result  = 1'b0;
    return t;
  endfunction

  // Input register
  logic        full_r, full_nxt;
  in_t         in_r;

  // Lexer state
  mode_t             mode_r, mode_nxt;
  logic [7:0]        la1_r, la1_nxt;
  logic              la2_r, la2_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [COL_W-1:0]  tsc_r, tsc_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [1:0]        dots_r, dots_nxt;
  logic              ps_r, ps_nxt;
  logic              halt_r, halt_nxt;
  logic [2:0]        hk_r, hk_nxt;
  logic [3:0]        hc_r, hc_nxt;
  logic [7:0]        hf_r, hf_nxt;

  logic        fire;
  logic [7:0]  b;
  logic        ws, do_start, sb;
  pcode_t      pc;
  logic [2:0]  n;
  tok_t [MAX_RES-1:0] res;

  assign busy = full_r;
  assign fire = full_r && go;
  assign b    = in_r.text_byte;
  assign ws   = is_ws(b);
  assign full_nxt = load || (full_r && !go);

  always_comb begin
    mode_nxt = mode_r; la1_nxt = la1_r; la2_nxt = la2_r; line_nxt = line_r;
    col_nxt = col_r; tsc_nxt = tsc_r; len_nxt = len_r; dots_nxt = dots_r;
    ps_nxt = ps_r; halt_nxt = halt_r; hk_nxt = hk_r; hc_nxt = hc_r; hf_nxt = hf_r;
    do_start = 1'b0;
    sb = 1'b0;
    n = '0;
    res = '0;
    pc = pair_code(la1_r, b);
    if (!halt_r) begin
      case (mode_r)
        M_NUM: begin
          if (is_digit(b) || b == CH_DOT) begin
            len_nxt = inc_len(len_nxt);
            if (b == CH_DOT && dots_nxt != 2'd3) dots_nxt = dots_nxt + 2'd1;
            col_nxt = inc_col(col_nxt);
          end else begin
            sb = ps_nxt; ps_nxt = 1'b0;
            if (dots_nxt >= 2'd2) begin
              res[n[1:0]] = mk(TK_BADNUM, PC_SINGLE, hf_nxt, line_nxt, tsc_nxt, len_nxt, sb, 1'b0);
              halt_nxt = 1'b1;
            end else begin
              res[n[1:0]] = mk((dots_nxt != 2'd0) ? TK_FLOAT : TK_INT, PC_SINGLE, hf_nxt,
                               line_nxt, tsc_nxt, len_nxt, sb, ws);
              do_start = 1'b1;
            end
            n = n + 3'd1;
            mode_nxt = M_IDLE;
          end
        end
        M_IDENT: begin
          if (is_alpha(b) || is_digit(b) || b == CH_UNDER) begin
            len_nxt = inc_len(len_nxt);
            col_nxt = inc_col(col_nxt);
          end else begin
            sb = ps_nxt; ps_nxt = 1'b0;
            res[n[1:0]] = mk(TK_IDENT, PC_SINGLE, hf_nxt, line_nxt, tsc_nxt, len_nxt, sb, ws);
            n = n + 3'd1;
            do_start = 1'b1;
          end
        end
        M_STR: begin
          len_nxt = inc_len(len_nxt);
          col_nxt = inc_col(col_nxt);
          if (b == CH_QUOTE) begin
            hk_nxt = TK_STRING; hc_nxt = PC_SINGLE; mode_nxt = M_HELD;
          end
        end
        M_LCOM: begin
          if (b == CH_NL) do_start = 1'b1;
          else col_nxt = inc_col(col_nxt);
        end
        M_BCOM, M_BSTAR: begin
          col_nxt = inc_col(col_nxt);
          if (mode_r == M_BSTAR && b == CH_SLASH) mode_nxt = M_IDLE;
          else mode_nxt = (b == CH_STAR) ? M_BSTAR : M_BCOM;
        end
        M_PEND: begin
          if (!la2_r) begin
            if (la1_r == CH_SLASH && b == CH_SLASH) begin
              mode_nxt = M_LCOM; col_nxt = inc_col(col_nxt);
            end else if (la1_r == CH_SLASH && b == CH_STAR) begin
              mode_nxt = M_BCOM; col_nxt = inc_col(col_nxt);
            end else if (pc != PC_SINGLE) begin
              len_nxt = LEN_W'(2); hk_nxt = TK_PUNCT; hc_nxt = pc; mode_nxt = M_HELD;
              col_nxt = inc_col(col_nxt);
            end else if (la1_r == CH_DOT && b == CH_DOT) begin
              la2_nxt = 1'b1; len_nxt = LEN_W'(2); col_nxt = inc_col(col_nxt);
            end else begin
              sb = ps_nxt; ps_nxt = 1'b0;
              res[n[1:0]] = mk(TK_PUNCT, PC_SINGLE, la1_r, line_nxt, tsc_nxt, LEN_W'(1), sb, ws);
              n = n + 3'd1;
              do_start = 1'b1;
            end
          end else begin
            if (b == CH_DOT || b == CH_LT) begin
              len_nxt = LEN_W'(3); hk_nxt = TK_PUNCT;
              hc_nxt = (b == CH_DOT) ? PC_ELLIP : PC_RANGE;
              mode_nxt = M_HELD; col_nxt = inc_col(col_nxt);
            end else begin
              res[0] = mk(TK_PUNCT, PC_SINGLE, CH_DOT, line_nxt, tsc_nxt, LEN_W'(1), ps_nxt, 1'b0);
              res[1] = mk(TK_PUNCT, PC_SINGLE, CH_DOT, line_nxt, inc_col(tsc_nxt), LEN_W'(1),
                          1'b0, ws);
              ps_nxt = 1'b0;
              n = 3'd2;
              do_start = 1'b1;
            end
          end
        end
        M_HELD: begin
          sb = ps_nxt; ps_nxt = 1'b0;
          res[n[1:0]] = mk(hk_nxt, hc_nxt, hf_nxt, line_nxt, tsc_nxt, len_nxt, sb, ws);
          n = n + 3'd1;
          do_start = 1'b1;
        end
        default: do_start = 1'b1;
      endcase
    end

    if (do_start) begin
      mode_nxt = M_IDLE;
      if (ws) begin
        ps_nxt = 1'b1;
        if (b == CH_NL) begin
          line_nxt = inc_line(line_nxt);
          col_nxt = COL_W'(1);
        end else begin
          col_nxt = inc_col(col_nxt);
        end
      end else begin
        tsc_nxt = col_nxt; len_nxt = LEN_W'(1); hf_nxt = b; dots_nxt = 2'd0;
        if (is_digit(b)) mode_nxt = M_NUM;
        else if (is_alpha(b) || b == CH_UNDER) mode_nxt = M_IDENT;
        else if (b == CH_QUOTE) mode_nxt = M_STR;
        else if (starts_pend(b)) begin
          mode_nxt = M_PEND; la1_nxt = b; la2_nxt = 1'b0;
        end else begin
          hk_nxt = TK_PUNCT; hc_nxt = PC_SINGLE; mode_nxt = M_HELD;
        end
        col_nxt = inc_col(col_nxt);
      end
    end

    if (in_r.end_of_text) begin
      if (!halt_nxt) begin
        case (mode_nxt)
          M_NUM: begin
            res[n[1:0]] = mk((dots_nxt >= 2'd2) ? TK_BADNUM :
                             (dots_nxt != 2'd0) ? TK_FLOAT : TK_INT, PC_SINGLE, hf_nxt,
                             line_nxt, tsc_nxt, len_nxt, ps_nxt, 1'b0);
            n = n + 3'd1;
          end
          M_IDENT: begin
            res[n[1:0]] = mk(TK_IDENT, PC_SINGLE, hf_nxt, line_nxt, tsc_nxt, len_nxt, ps_nxt, 1'b0);
            n = n + 3'd1;
          end
          M_STR: begin
            res[n[1:0]] = mk(TK_UNTERM, PC_SINGLE, hf_nxt, line_nxt, tsc_nxt, len_nxt, ps_nxt, 1'b0);
            n = n + 3'd1;
          end
          M_HELD: begin
            res[n[1:0]] = mk(hk_nxt, hc_nxt, hf_nxt, line_nxt, tsc_nxt, len_nxt, ps_nxt, 1'b0);
            n = n + 3'd1;
          end
          M_PEND: begin
            if (!la2_nxt) begin
              res[n[1:0]] = mk(TK_PUNCT, PC_SINGLE, la1_nxt, line_nxt, tsc_nxt, LEN_W'(1),
                               ps_nxt, 1'b0);
              n = n + 3'd1;
            end else begin
              res[n[1:0]] = mk(TK_PUNCT, PC_SINGLE, CH_DOT, line_nxt, tsc_nxt, LEN_W'(1),
                               ps_nxt, 1'b0);
              n = n + 3'd1;
              res[n[1:0]] = mk(TK_PUNCT, PC_SINGLE, CH_DOT, line_nxt, inc_col(tsc_nxt),
                               LEN_W'(1), 1'b0, 1'b0);
              n = n + 3'd1;
            end
          end
          default: ;
        endcase
      end
      res[n[1:0]] = mk(TK_END, PC_SINGLE, 8'd0, (b == CH_NL) ? line_nxt : inc_line(line_nxt),
                       COL_W'(1), '0, 1'b0, 1'b0);
      n = n + 3'd1;
      // Return to reset for the next text.
      mode_nxt = M_IDLE; la1_nxt = '0; la2_nxt = 1'b0; line_nxt = LINE_W'(1);
      col_nxt = COL_W'(1); tsc_nxt = COL_W'(1); len_nxt = '0; dots_nxt = '0;
      ps_nxt = 1'b0; halt_nxt = 1'b0; hk_nxt = '0; hc_nxt = '0; hf_nxt = '0;
    end
    if (n != 3'd0) res[2'(n - 3'd1)].last_result = 1'b1;
  end

  always_comb begin
    push.tok = res;
    push.cnt = fire ? n : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (load) in_r <= in_data;
    if (!rst_n) begin
      full_r <= 1'b0;
      mode_r <= M_IDLE; la1_r <= '0; la2_r <= 1'b0; line_r <= LINE_W'(1);
      col_r <= COL_W'(1); tsc_r <= COL_W'(1); len_r <= '0; dots_r <= '0;
      ps_r <= 1'b0; halt_r <= 1'b0; hk_r <= '0; hc_r <= '0; hf_r <= '0;
    end else begin
      full_r <= full_nxt;
      if (fire) begin
        mode_r <= mode_nxt; la1_r <= la1_nxt; la2_r <= la2_nxt; line_r <= line_nxt;
        col_r <= col_nxt; tsc_r <= tsc_nxt; len_r <= len_nxt; dots_r <= dots_nxt;
        ps_r <= ps_nxt; halt_r <= halt_nxt; hk_r <= hk_nxt; hc_r <= hc_nxt; hf_r <= hf_nxt;
      end
    end
  end

endmodule

### rtl/sct_fifo.sv
// Result queue: takes up to four results a cycle, delivers one.
module sct_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  sct_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_stall,
  output sct_pkg::tok_t  out_data
);
  import sct_pkg::*;

  localparam int DEPTH = 8;
  localparam int AW    = $clog2(DEPTH);

  tok_t          q_r [DEPTH];
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          pop;

  assign out_valid = cnt_r != '0;
  assign out_data  = q_r[head_r];
  assign pop       = out_valid && !out_stall;
  assign room      = cnt_r <= (AW+1)'(DEPTH - MAX_RES);

  always_comb begin
    head_nxt = head_r + AW'(pop);
    tail_nxt = tail_r + AW'(push.cnt);
    cnt_nxt  = cnt_r + (AW+1)'(push.cnt) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (3'(i) < push.cnt) q_r[tail_r + AW'(i)] <= push.tok[i];
    end
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

### rtl/source_code_tokenizer.sv
// Top level of the source code tokenizer.
//
//  channel | direction | payload          | handshake
//  in_     | input     | sct_pkg::in_t    | in_valid / in_stall
//  out_    | output    | sct_pkg::tok_t   | out_valid / out_stall
//
// One byte a cycle is accepted unless in_stall; a byte's zero to four tokens
// appear one a cycle unless out_stall, from an eight-entry result queue, set
// by the single output port. The input stalls while a byte is held and the
// queue holds more than four entries. Each byte is registered, then queued.
// Reset (rst_n low, synchronous) empties the queue and input register and
// returns the scanner to line 1, column 1, between tokens.
module source_code_tokenizer (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sct_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output sct_pkg::tok_t out_data
);
  import sct_pkg::*;

  logic  busy, room, load;
  push_t push;

  // Hold the input while the held byte cannot be processed for lack of room.
  assign in_stall = busy && !room;
  assign load     = in_valid && !in_stall;

  // Scanner: advance lexer state once per processed byte.
  sct_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .in_data (in_data),
    .go      (room),
    .busy    (busy),
    .push    (push)
  );

  // Queue: drop one token per output transaction.
  sct_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/sct_checker.sv
// Port-level checker for the tokenizer and its bind.
`include "source_code_tokenizer_defines.svh"

module sct_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_stall,
  input sct_pkg::tok_t out_data
);
  import sct_pkg::*;

  logic is_end, end_ok;

  assign is_end = out_valid && out_data.token_kind == TK_END;
  assign end_ok = out_data.last_result && out_data.token_length == '0;

  `SCT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "output valid dropped")
  `SCT_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_data), "output changed")
  `SCT_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "output valid after reset")
  `SCT_ASSERT(a_end_last, is_end |-> end_ok, "bad end token")

endmodule

bind source_code_tokenizer sct_checker u_sct_checker (.*);

### tb/sv/testbench.sv
// Self-checking testbench of the source code tokenizer.
`timescale 1ns / 100ps

module testbench;
  import sct_pkg::*;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  tok_t  out_data;

  source_code_tokenizer i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Scanner state mirrored from the block.
  mode_t       scan_mode;
  logic [15:0] look_bytes;
  logic [1:0]  look_count;
  logic [19:0] cur_line;
  logic [15:0] cur_col;
  logic [15:0] tok_col;
  logic [15:0] tok_len;
  logic [1:0]  dots;
  logic        space_pending;
  logic        halted;
  kind_t       held_kind;
  pcode_t      held_code;
  logic [7:0]  held_first;

  in_t  pending_bytes[$];
  tok_t expected_tokens[$];
  int   emitted;
  int   failures = 0;
  int   queued_bytes = 0;
  bit   pause_req = 1'b0;
  bit   pause_done = 1'b0;
  int   stall_pct = 20;

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_ws(logic [7:0] b);
    return b == CH_SPACE || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic bit starts_op(logic [7:0] b);
    return b == CH_SLASH || b == CH_EQ || b == CH_BANG || b == CH_LT || b == CH_GT ||
           b == CH_AMP || b == CH_BAR || b == CH_MINUS || b == CH_DOT;
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] v, logic [31:0] top);
    return v >= top ? top : v + 1;
  endfunction

  function automatic pcode_t pair_code(logic [7:0] a, logic [7:0] b);
    if (a == CH_EQ && b == CH_EQ) return PC_EQ;
    if (a == CH_BANG && b == CH_EQ) return PC_NE;
    if (a == CH_LT && b == CH_EQ) return PC_LE;
    if (a == CH_GT && b == CH_EQ) return PC_GE;
    if (a == CH_AMP && b == CH_AMP) return PC_AND;
    if (a == CH_BAR && b == CH_BAR) return PC_OR;
    if (a == CH_MINUS && b == CH_GT) return PC_ARROW;
    if (a == CH_EQ && b == CH_GT) return PC_FATARR;
    return PC_SINGLE;
  endfunction

  task automatic clear_scanner();
    scan_mode = M_IDLE;
    look_bytes = '0;
    look_count = '0;
    cur_line = 20'd1;
    cur_col = 16'd1;
    tok_col = 16'd1;
    tok_len = '0;
    dots = '0;
    space_pending = 1'b0;
    halted = 1'b0;
    held_kind = TK_INT;
    held_code = PC_SINGLE;
    held_first = '0;
  endtask

  // Append one expected token; the block caps a byte at four.
  task automatic emit(kind_t k, pcode_t c, logic [7:0] f, logic [19:0] ln,
                      logic [15:0] col, logic [15:0] len, logic sa);
    tok_t t;
    if (emitted >= MAX_RES) return;
    t.token_kind = k;
    t.punct_code = c;
    t.first_char = f;
    t.start_line = ln;
    t.start_column = col;
    t.token_length = len;
    t.space_before = space_pending;
    t.space_after = sa;
    t.last_result = 1'b0;
    space_pending = 1'b0;
    expected_tokens = {expected_tokens, t};
    emitted++;
  endtask

  task automatic emit_held(kind_t k, pcode_t c, logic sa);
    emit(k, c, held_first, cur_line, tok_col, tok_len, sa);
  endtask

  task automatic bump_col();
    cur_col = 16'(sat_inc(cur_col, COL_TOP));
  endtask

  task automatic hold_token(kind_t k, pcode_t c);
    held_kind = k;
    held_code = c;
    scan_mode = M_HELD;
  endtask

  task automatic begin_token(logic [7:0] b);
    scan_mode = M_IDLE;
    if (is_ws(b)) begin
      space_pending = 1'b1;
      if (b == CH_NL) begin
        cur_line = 20'(sat_inc(cur_line, LINE_TOP));
        cur_col = 16'd1;
      end else begin
        bump_col();
      end
      return;
    end
    tok_col = cur_col;
    tok_len = 16'd1;
    held_first = b;
    dots = '0;
    if (is_digit(b)) scan_mode = M_NUM;
    else if (is_alpha(b) || b == CH_UNDER) scan_mode = M_IDENT;
    else if (b == CH_QUOTE) scan_mode = M_STR;
    else if (starts_op(b)) begin
      scan_mode = M_PEND;
      look_bytes = {8'd0, b};
      look_count = 2'd1;
    end else hold_token(TK_PUNCT, PC_SINGLE);
    bump_col();
  endtask

  task automatic close_number(logic sa);
    if (dots >= 2) begin
      emit_held(TK_BADNUM, PC_SINGLE, 1'b0);
      halted = 1'b1;
    end else begin
      emit_held(dots != 0 ? TK_FLOAT : TK_INT, PC_SINGLE, sa);
    end
    scan_mode = M_IDLE;
  endtask

  task automatic split_dots(logic sa);
    emit(TK_PUNCT, PC_SINGLE, CH_DOT, cur_line, tok_col, 16'd1, 1'b0);
    emit(TK_PUNCT, PC_SINGLE, CH_DOT, cur_line, 16'(sat_inc(tok_col, COL_TOP)), 16'd1, sa);
  endtask

  task automatic scan_byte(logic [7:0] b);
    logic [7:0] c1;
    pcode_t     pc;
    logic       ws;
    c1 = look_bytes[7:0];
    ws = is_ws(b);
    case (scan_mode)
      M_NUM: begin
        if (is_digit(b) || b == CH_DOT) begin
          tok_len = 16'(sat_inc(tok_len, LEN_TOP));
          if (b == CH_DOT && dots < 3) dots++;
          bump_col();
        end else begin
          close_number(ws);
          if (!halted) begin_token(b);
        end
      end
      M_IDENT: begin
        if (is_alpha(b) || is_digit(b) || b == CH_UNDER) begin
          tok_len = 16'(sat_inc(tok_len, LEN_TOP));
          bump_col();
        end else begin
          emit_held(TK_IDENT, PC_SINGLE, ws);
          begin_token(b);
        end
      end
      M_STR: begin
        tok_len = 16'(sat_inc(tok_len, LEN_TOP));
        bump_col();
        if (b == CH_QUOTE) hold_token(TK_STRING, PC_SINGLE);
      end
      M_LCOM: begin
        if (b == CH_NL) begin_token(b);
        else bump_col();
      end
      M_BCOM, M_BSTAR: begin
        bump_col();
        if (scan_mode == M_BSTAR && b == CH_SLASH) scan_mode = M_IDLE;
        else scan_mode = (b == CH_STAR) ? M_BSTAR : M_BCOM;
      end
      M_PEND: begin
        if (look_count == 2'd1) begin
          pc = pair_code(c1, b);
          if (c1 == CH_SLASH && b == CH_SLASH) begin
            scan_mode = M_LCOM;
            bump_col();
          end else if (c1 == CH_SLASH && b == CH_STAR) begin
            scan_mode = M_BCOM;
            bump_col();
          end else if (pc != PC_SINGLE) begin
            tok_len = 16'd2;
            hold_token(TK_PUNCT, pc);
            bump_col();
          end else if (c1 == CH_DOT && b == CH_DOT) begin
            look_count = 2'd2;
            look_bytes = {b, c1};
            tok_len = 16'd2;
            bump_col();
          end else begin
            emit(TK_PUNCT, PC_SINGLE, c1, cur_line, tok_col, 16'd1, ws);
            begin_token(b);
          end
        end else if (b == CH_DOT || b == CH_LT) begin
          tok_len = 16'd3;
          hold_token(TK_PUNCT, b == CH_DOT ? PC_ELLIP : PC_RANGE);
          bump_col();
        end else begin
          split_dots(ws);
          begin_token(b);
        end
      end
      M_HELD: begin
        emit_held(held_kind, held_code, ws);
        begin_token(b);
      end
      default: begin_token(b);
    endcase
  endtask

  // Predict the tokens of one accepted byte and queue them.
  task automatic predict_tokens(in_t item);
    logic [19:0] end_line;
    emitted = 0;
    if (!halted) scan_byte(item.text_byte);
    if (item.end_of_text) begin
      if (!halted) begin
        case (scan_mode)
          M_NUM: close_number(1'b0);
          M_IDENT: emit_held(TK_IDENT, PC_SINGLE, 1'b0);
          M_STR: emit_held(TK_UNTERM, PC_SINGLE, 1'b0);
          M_HELD: emit_held(held_kind, held_code, 1'b0);
          M_PEND: begin
            if (look_count == 2'd1)
              emit(TK_PUNCT, PC_SINGLE, look_bytes[7:0], cur_line, tok_col, 16'd1, 1'b0);
            else
              split_dots(1'b0);
          end
          default: ;
        endcase
      end
      end_line = (item.text_byte == CH_NL) ? cur_line : 20'(sat_inc(cur_line, LINE_TOP));
      space_pending = 1'b0;
      emit(TK_END, PC_SINGLE, 8'd0, end_line, 16'd1, 16'd0, 1'b0);
      clear_scanner();
    end
    if (emitted > 0) expected_tokens[$].last_result = 1'b1;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Acceptance seen at the last rising edge; set once the driver may move on.
  logic in_stall_seen = 1'b1;

  // Driver: present one transaction at a time, hold it while stalled.
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_seen) begin
        // hold the payload, wait for acceptance
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pause_req && expected_tokens.size() != 0) begin
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        if (pause_req) begin
          pause_done = 1'b1;
          pause_req = 1'b0;
        end
        in_data <= pending_bytes.pop_front();
        in_valid <= 1'b1;
        send_gap <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_stall_seen <= 1'b1;
    end else if (in_valid && !in_stall) begin
      predict_tokens(in_data);
      in_stall_seen <= 1'b1;
    end else begin
      in_stall_seen <= !in_valid;
    end
  end

  // Receiver stall: random, with stretches of none.
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= gap_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: compare every accepted token with the oldest prediction.
  tok_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token, actual %p", $realtime, out_data);
        failures++;
      end else begin
        want = expected_tokens.pop_front();
        if (out_data !== want) begin
          $display("%0t: token mismatch, expected %p, actual %p", $realtime, want, out_data);
          failures++;
        end
      end
    end
  end

  task automatic add_text(string s, bit close);
    in_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.text_byte = s[i];
      it.end_of_text = close && (i == s.len() - 1);
      pending_bytes = {pending_bytes, it};
      queued_bytes++;
    end
  endtask

  task automatic add_byte(logic [7:0] b, bit close);
    in_t it;
    it.text_byte = b;
    it.end_of_text = close;
    pending_bytes = {pending_bytes, it};
    queued_bytes++;
  endtask

  // Random snippet, mostly well-formed lexemes.
  function automatic string rand_lexeme();
    string s;
    string ops[$] = '{"==", "!=", "<=", ">=", "&&", "||", "->", "=>", "...", "..<",
                      "..", ".", "/", "<", "=", "-", "+", "(", ";", "{"};
    string ws[$] = '{" ", "\n", "\t", "\r", "  ", "\n\n"};
    s = "";
    case ($urandom_range(0, 11))
      0, 1: for (int i = $urandom_range(1, 4); i > 0; i--) s = {s, "9"};
      2: s = $sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 99));
      3: s = $sformatf("%0d.%0d.%0d", $urandom_range(0, 9), $urandom_range(0, 9),
                       $urandom_range(0, 9));
      4, 5: s = $sformatf("%s_x%0d", $urandom_range(0, 1) ? "Ab" : "zq",
                          $urandom_range(0, 99));
      6: s = "\"s\ni*/ \"";
      7: s = ops[$urandom_range(0, ops.size() - 1)];
      8: s = "// note\n";
      9: s = "/* a\n** */";
      10: s = ws[$urandom_range(0, ws.size() - 1)];
      default: begin
        s = " ";
        s[0] = 8'($urandom_range(1, 255));
      end
    endcase
    return s;
  endfunction

  logic [7:0] all_ones = 8'hFF;
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    string t;
    clear_scanner();
    // Directed texts: every kind, every operator, errors and edge bytes.
    add_text("a1_ 42 3.5 \"q\" == != <= >= && || -> => ... ..< .. . x", 1);
    add_text("1.2.3 rest ignored", 1);
    add_text("\"open\nstring", 1);
    add_text("/* never closed", 1);
    add_text("// c\n_z\t", 0);
    add_byte(8'h00, 0);
    add_byte(all_ones, 0);
    add_byte(8'h80, 0);
    add_byte(CH_NL, 1);
    add_byte(CH_DOT, 1);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // Random texts until about 360 bytes are queued.
    while (queued_bytes < 360) begin
      t = "";
      for (int i = $urandom_range(1, 8); i > 0; i--) t = {t, rand_lexeme()};
      add_text(t, $urandom_range(0, 3) != 0);
      if (queued_bytes > 180 && !pause_req && !pause_done) begin
        wait (pending_bytes.size() == 0);
        pause_req = 1'b1;
      end
    end
    add_text(";", 1);
    wait (pause_done && pending_bytes.size() == 0);
    stall_pct = 30;
    wait (expected_tokens.size() == 0 && !in_valid);
    repeat (20) @(posedge clk);
    if (failures == 0 && expected_tokens.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
